@@ hw/rtl/glps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glps_pkg: shared types, constants and arithmetic helpers
// Fixed point constants in Q28, stage control vector, status and register
// codes, plus rounding, clamping and colour conversion functions.
// ----------------------------------------------------------------------------
package glps_pkg;

  localparam int COLOR_FRAC_BITS = 15;
  localparam int COLOR_SHIFT     = 28 - COLOR_FRAC_BITS;
  localparam int PIPE_DEPTH      = 10;
  localparam int ADDR_W          = 6;
  localparam int DATA_W          = 64;

  localparam logic [28:0] Q_ONE        = 29'd268435456;
  localparam logic [29:0] LC_LIMIT     = 30'd536870912;
  localparam logic [27:0] K_GLOSS_FALL = 28'd241591910;
  localparam logic [30:0] K_GLOSS_GAIN = 31'd1207959552;
  localparam logic [28:0] K_AMB_GAIN   = 29'd402653184;
  localparam logic [27:0] K_AMB_FG     = 28'd147639501;
  localparam logic [15:0] COLOR_GREY   = 16'd4096;
  localparam logic [15:0] COLOR_MAX    = 16'hFFFF;

  typedef logic [PIPE_DEPTH:1] stage_vec_t;

  typedef enum logic [1:0] {
    HIT_SHADED      = 2'd0,
    HIT_ZERO_NORMAL = 2'd1,
    HIT_BACK        = 2'd2
  } hit_status_t;

  typedef enum logic [2:0] {
    REG_LIGHT_DIR_X   = 3'd0,
    REG_LIGHT_DIR_Y   = 3'd1,
    REG_LIGHT_DIR_Z   = 3'd2,
    REG_LIGHT_COLOR   = 3'd3,
    REG_AMBIENT_FRAC  = 3'd4
  } cfg_reg_t;

  // Round an unsigned product of two Q28 values back to Q28, half up.
  function automatic logic [35:0] q28_round(input logic [63:0] p);
    logic [63:0] s;
    s = p + 64'd134217728;
    return s[63:28];
  endfunction

  // Clamp a signed Q28 value to [-1, 1].
  function automatic logic signed [29:0] clamp_unit(input logic signed [35:0] x);
    logic signed [29:0] r;
    if (x > 36'sd268435456) begin
      r = 30'sd268435456;
    end else if (x < -36'sd268435456) begin
      r = -30'sd268435456;
    end else begin
      r = x[29:0];
    end
    return r;
  endfunction

  // Move a colour field to Q28 and clamp it.
  function automatic logic [29:0] color_q28(input logic [15:0] field,
                                            input logic [29:0] limit);
    logic [39:0] v;
    v = 40'(field) << COLOR_SHIFT;
    return (v > 40'(limit)) ? limit : v[29:0];
  endfunction

  // Round a Q28 sum to Q3.13 and saturate.
  function automatic logic [15:0] color_out(input logic [33:0] sum);
    logic [34:0] r;
    r = 35'(sum) + 35'd16384;
    return (r[34:15] > 20'd65535) ? COLOR_MAX : r[30:15];
  endfunction

endpackage

@@ hw/rtl/glps_pixel_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glps_pixel_if: pixel input channel
// Valid/ready channel carrying normal, view ray and per-channel coefficients.
// ----------------------------------------------------------------------------
interface glps_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic        [15:0] gloss_red;
  logic        [15:0] gloss_green;
  logic        [15:0] gloss_blue;
  logic        [15:0] albedo_red;
  logic        [15:0] albedo_green;
  logic        [15:0] albedo_blue;

  modport source (
    output valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
    output gloss_red, gloss_green, gloss_blue,
    output albedo_red, albedo_green, albedo_blue,
    input  ready
  );

  modport sink (
    input  valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
    input  gloss_red, gloss_green, gloss_blue,
    input  albedo_red, albedo_green, albedo_blue,
    output ready
  );
endinterface

@@ hw/rtl/glps_color_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glps_color_if: shaded colour output channel
// Valid/ready channel carrying RGB brightness and hit status.
// ----------------------------------------------------------------------------
interface glps_color_if;
  logic        valid;
  logic        ready;
  logic [15:0] color_red;
  logic [15:0] color_green;
  logic [15:0] color_blue;
  logic [1:0]  hit_status;

  modport source (
    output valid, color_red, color_green, color_blue, hit_status,
    input  ready
  );

  modport sink (
    input  valid, color_red, color_green, color_blue, hit_status,
    output ready
  );
endinterface

@@ hw/rtl/glps_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glps_channel: per-colour shading datapath
// Directional and ambient layers for one colour channel, stages 1 to 9.
// ----------------------------------------------------------------------------
module glps_channel (
  input  logic                 clk,
  input  glps_pkg::stage_vec_t load,
  input  logic [15:0]          gloss_field,
  input  logic [15:0]          albedo_field,
  input  logic [29:0]          light_q28,
  input  logic [28:0]          amb_q28,
  input  logic [28:0]          dnl_mag,
  input  logic                 dnl_pos,
  input  logic [28:0]          fg_eff,
  input  logic [30:0]          ag,
  input  logic [28:0]          agi,
  output logic [33:0]          sum
);

  logic [29:0] g_full;
  logic [29:0] a_full;
  logic [28:0] amb_comp;

  logic [28:0] s1_g, s1_a, s2_g, s2_a, s3_g, s3_a, s4_g, s4_a;
  logic [58:0] s3_lcd_raw;
  logic [29:0] s4_lcd;
  logic [57:0] s5_fgg_raw;
  logic [56:0] s5_iso_raw;
  logic [58:0] s5_el_raw;
  logic [28:0] s5_a;
  logic [58:0] s6_eg_raw;
  logic [56:0] s6_egi_raw;
  logic [29:0] s6_el;
  logic [28:0] s6_a;
  logic [29:0] s7_eg, s7_el2;
  logic [28:0] s7_egi, s7_eli, s7_a;
  logic [60:0] s8_p1;
  logic [58:0] s8_p2;
  logic [57:0] s8_p3, s8_p4;
  logic [33:0] s9_sum;

  logic [35:0] lcd_r, fgg_r, iso_r, el_r, eg_r, egi_r;
  logic [35:0] p1_r, p2_r, p3_r, p4_r;
  logic [29:0] el_gated;

  assign g_full   = glps_pkg::color_q28(gloss_field, 30'(glps_pkg::Q_ONE));
  assign a_full   = glps_pkg::color_q28(albedo_field, 30'(glps_pkg::Q_ONE));
  assign amb_comp = glps_pkg::Q_ONE - amb_q28;

  assign lcd_r = glps_pkg::q28_round(64'(s3_lcd_raw));
  assign fgg_r = glps_pkg::q28_round(64'(s5_fgg_raw));
  assign iso_r = glps_pkg::q28_round(64'(s5_iso_raw));
  assign el_r  = glps_pkg::q28_round(64'(s5_el_raw));
  assign eg_r  = glps_pkg::q28_round(64'(s6_eg_raw));
  assign egi_r = glps_pkg::q28_round(64'(s6_egi_raw));
  assign p1_r  = glps_pkg::q28_round(64'(s8_p1));
  assign p2_r  = glps_pkg::q28_round(64'(s8_p2));
  assign p3_r  = glps_pkg::q28_round(64'(s8_p3));
  assign p4_r  = glps_pkg::q28_round(64'(s8_p4));

  // No directional light reaches a surface turned away from it.
  assign el_gated = dnl_pos ? el_r[29:0] : '0;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_g <= g_full[28:0];
      s1_a <= a_full[28:0];
    end
    if (load[2]) begin
      s2_g <= s1_g;
      s2_a <= s1_a;
    end
    if (load[3]) begin
      s3_g       <= s2_g;
      s3_a       <= s2_a;
      s3_lcd_raw <= 59'(light_q28) * 59'(dnl_mag);
    end
    if (load[4]) begin
      s4_g   <= s3_g;
      s4_a   <= s3_a;
      s4_lcd <= lcd_r[29:0];
    end
    if (load[5]) begin
      s5_fgg_raw <= 58'(fg_eff) * 58'(s4_g);
      s5_iso_raw <= 57'(glps_pkg::K_AMB_FG) * 57'(s4_g);
      s5_el_raw  <= 59'(amb_comp) * 59'(s4_lcd);
      s5_a       <= s4_a;
    end
    if (load[6]) begin
      s6_eg_raw  <= 59'(fgg_r[28:0]) * 59'(el_gated);
      s6_egi_raw <= 57'(iso_r[27:0]) * 57'(amb_q28);
      s6_el      <= el_gated;
      s6_a       <= s5_a;
    end
    if (load[7]) begin
      s7_eg  <= eg_r[29:0];
      s7_el2 <= s6_el - eg_r[29:0];
      s7_egi <= egi_r[28:0];
      s7_eli <= amb_q28 - egi_r[28:0];
      s7_a   <= s6_a;
    end
    if (load[8]) begin
      s8_p1 <= 61'(ag) * 61'(s7_eg);
      s8_p2 <= 59'(s7_el2) * 59'(s7_a);
      s8_p3 <= 58'(agi) * 58'(s7_egi);
      s8_p4 <= 58'(s7_eli) * 58'(s7_a);
    end
    if (load[9]) begin
      s9_sum <= p1_r[33:0] + p2_r[33:0] + p3_r[33:0] + p4_r[33:0];
    end
  end

  assign sum = s9_sum;

endmodule

@@ hw/rtl/glossy_lambert_pixel_shader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glossy_lambert_pixel_shader: glossy plus Lambertian pixel shader
// Pipeline: ten register stages, set by the chain of dependent Q28 products;
//   the colour word is offered from the stage 10 output register.
// Throughput: one pixel word per cycle while the output is not stalled; each
//   stage holds its own valid bit, a stalled output holds while upstream
//   bubbles keep filling.
// Reset clears the stage valid bits and the light configuration registers.
// ----------------------------------------------------------------------------
module glossy_lambert_pixel_shader (
  input  logic                         clk,
  input  logic                         rst,
  glps_pixel_if.sink                   pixel,
  glps_color_if.source                 color,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [glps_pkg::ADDR_W-1:0]  paddr,
  input  logic [glps_pkg::DATA_W-1:0]  pwdata,
  output logic [glps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  // --------------------------------------------------------------------------
  // Configuration registers (APB, 8-byte stride, writes in the access phase)
  // --------------------------------------------------------------------------
  logic signed [15:0] light_dir_x, light_dir_y, light_dir_z;
  logic [47:0]        light_color_packed;
  logic [47:0]        ambient_fraction_packed;
  logic               cfg_write;
  glps_pkg::cfg_reg_t cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = glps_pkg::cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      light_dir_x             <= '0;
      light_dir_y             <= '0;
      light_dir_z             <= '0;
      light_color_packed      <= '0;
      ambient_fraction_packed <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        glps_pkg::REG_LIGHT_DIR_X:  light_dir_x             <= pwdata[15:0];
        glps_pkg::REG_LIGHT_DIR_Y:  light_dir_y             <= pwdata[15:0];
        glps_pkg::REG_LIGHT_DIR_Z:  light_dir_z             <= pwdata[15:0];
        glps_pkg::REG_LIGHT_COLOR:  light_color_packed      <= pwdata[47:0];
        glps_pkg::REG_AMBIENT_FRAC: ambient_fraction_packed <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      glps_pkg::REG_LIGHT_DIR_X:  prdata = 64'(light_dir_x);
      glps_pkg::REG_LIGHT_DIR_Y:  prdata = 64'(light_dir_y);
      glps_pkg::REG_LIGHT_DIR_Z:  prdata = 64'(light_dir_z);
      glps_pkg::REG_LIGHT_COLOR:  prdata = 64'(light_color_packed);
      glps_pkg::REG_AMBIENT_FRAC: prdata = 64'(ambient_fraction_packed);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  glps_pkg::stage_vec_t v;
  glps_pkg::stage_vec_t ld;

  always_comb begin
    ld[glps_pkg::PIPE_DEPTH] = !v[glps_pkg::PIPE_DEPTH] || color.ready;
    for (int k = glps_pkg::PIPE_DEPTH - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign pixel.ready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= pixel.valid;
      end
      for (int k = 2; k <= glps_pkg::PIPE_DEPTH; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Geometry: dot products, clamps, mirror cosine and glossy weights
  // --------------------------------------------------------------------------
  logic signed [15:0] n_vec [3];
  logic signed [15:0] v_vec [3];
  logic signed [15:0] l_vec [3];

  assign n_vec[0] = pixel.normal_x;
  assign n_vec[1] = pixel.normal_y;
  assign n_vec[2] = pixel.normal_z;
  assign v_vec[0] = pixel.view_x;
  assign v_vec[1] = pixel.view_y;
  assign v_vec[2] = pixel.view_z;
  assign l_vec[0] = light_dir_x;
  assign l_vec[1] = light_dir_y;
  assign l_vec[2] = light_dir_z;

  // Stage 1: raw component products, already in Q28.
  logic signed [31:0] s1_nv [3];
  logic signed [31:0] s1_nl [3];
  logic signed [31:0] s1_vl [3];
  logic               s1_zero;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int c = 0; c < 3; c++) begin
        s1_nv[c] <= 32'(n_vec[c]) * 32'(v_vec[c]);
        s1_nl[c] <= 32'(n_vec[c]) * 32'(l_vec[c]);
        s1_vl[c] <= 32'(v_vec[c]) * 32'(l_vec[c]);
      end
      s1_zero <= (pixel.normal_x == '0) && (pixel.normal_y == '0) &&
                 (pixel.normal_z == '0);
    end
  end

  // Stage 2: sum, clamp and classify the hit.
  logic signed [35:0]    nv_sum, nl_sum, vl_sum;
  logic signed [29:0]    dnv_next;
  glps_pkg::hit_status_t status_next;
  logic signed [29:0]    s2_dnv, s2_dnl, s2_vl;
  glps_pkg::hit_status_t s2_status;

  assign nv_sum   = 36'(s1_nv[0]) + 36'(s1_nv[1]) + 36'(s1_nv[2]);
  assign nl_sum   = 36'(s1_nl[0]) + 36'(s1_nl[1]) + 36'(s1_nl[2]);
  assign vl_sum   = 36'(s1_vl[0]) + 36'(s1_vl[1]) + 36'(s1_vl[2]);
  assign dnv_next = glps_pkg::clamp_unit(-nv_sum);

  always_comb begin
    if (s1_zero) begin
      status_next = glps_pkg::HIT_ZERO_NORMAL;
    end else if (dnv_next <= 30'sd0) begin
      status_next = glps_pkg::HIT_BACK;
    end else begin
      status_next = glps_pkg::HIT_SHADED;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_dnv    <= dnv_next;
      s2_dnl    <= glps_pkg::clamp_unit(nl_sum);
      s2_vl     <= glps_pkg::clamp_unit(vl_sum);
      s2_status <= status_next;
    end
  end

  // Stage 3: magnitude products. Only shaded words use dnv, so it is
  // positive wherever its value matters.
  logic [29:0] dnl_abs;
  logic [28:0] dnl_mag;
  logic [57:0] s3_m1_raw;
  logic [56:0] s3_fg_raw;
  logic [57:0] s3_agi_raw;
  logic        s3_dnl_neg, s3_dnl_pos;
  logic signed [29:0] s3_vl;
  logic [28:0] s3_dnv_mag;
  glps_pkg::hit_status_t s3_status;

  assign dnl_abs = s2_dnl[29] ? 30'(-s2_dnl) : 30'(s2_dnl);
  assign dnl_mag = dnl_abs[28:0];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_m1_raw  <= 58'(dnl_mag) * 58'(s2_dnv[28:0]);
      s3_fg_raw  <= 57'(glps_pkg::K_GLOSS_FALL) * 57'(dnl_mag);
      s3_agi_raw <= 58'(glps_pkg::K_AMB_GAIN) * 58'(s2_dnv[28:0]);
      s3_dnl_neg <= s2_dnl < 30'sd0;
      s3_dnl_pos <= s2_dnl > 30'sd0;
      s3_vl      <= s2_vl;
      s3_dnv_mag <= s2_dnv[28:0];
      s3_status  <= s2_status;
    end
  end

  // Stage 4: mirror cosine, glossy fall-off and ambient gain.
  logic [35:0]        m1_r, fg_r, agi_r;
  logic signed [29:0] q_dnl_dnv;
  logic signed [29:0] dmv_next;
  logic signed [29:0] s4_dmv;
  logic               s4_gloss_on, s4_dnl_pos;
  logic [28:0]        s4_fg, s4_agi, s4_dnv_mag;
  logic [28:0]        fg_eff;
  glps_pkg::hit_status_t s4_status;

  assign m1_r      = glps_pkg::q28_round(64'(s3_m1_raw));
  assign fg_r      = glps_pkg::q28_round(64'(s3_fg_raw));
  assign agi_r     = glps_pkg::q28_round(64'(s3_agi_raw));
  assign q_dnl_dnv = s3_dnl_neg ? -$signed({1'b0, m1_r[28:0]}) : $signed({1'b0, m1_r[28:0]});
  assign dmv_next  = glps_pkg::clamp_unit((36'(q_dnl_dnv) <<< 1) + 36'(s3_vl));

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_dmv      <= dmv_next;
      s4_gloss_on <= s3_dnl_pos && (dmv_next > 30'sd0);
      s4_fg       <= glps_pkg::Q_ONE - fg_r[28:0];
      s4_agi      <= agi_r[28:0];
      s4_dnv_mag  <= s3_dnv_mag;
      s4_dnl_pos  <= s3_dnl_pos;
      s4_status   <= s3_status;
    end
  end

  // Drop the glossy layer when the light or its mirror is behind the surface.
  assign fg_eff = s4_gloss_on ? s4_fg : '0;

  // Stages 5 to 7: glossy gain 4.5 * dmv^2 * dnv.
  logic [57:0] s5_sq_raw;
  logic [28:0] s5_dnv_mag, s5_agi;
  logic        s5_gloss_on, s5_dnl_pos;
  glps_pkg::hit_status_t s5_status;
  logic [35:0] sq_r, sqd_r, ag_r;
  logic [57:0] s6_sqd_raw;
  logic [28:0] s6_agi;
  logic        s6_gloss_on;
  glps_pkg::hit_status_t s6_status;
  logic [59:0] s7_ag_raw;
  logic [28:0] s7_agi;
  logic        s7_gloss_on;
  glps_pkg::hit_status_t s7_status;
  logic [30:0] ag_s7;

  assign sq_r  = glps_pkg::q28_round(64'(s5_sq_raw));
  assign sqd_r = glps_pkg::q28_round(64'(s6_sqd_raw));
  assign ag_r  = glps_pkg::q28_round(64'(s7_ag_raw));
  assign ag_s7 = s7_gloss_on ? ag_r[30:0] : '0;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_sq_raw   <= 58'(s4_dmv[28:0]) * 58'(s4_dmv[28:0]);
      s5_dnv_mag  <= s4_dnv_mag;
      s5_agi      <= s4_agi;
      s5_gloss_on <= s4_gloss_on;
      s5_dnl_pos  <= s4_dnl_pos;
      s5_status   <= s4_status;
    end
    if (ld[6]) begin
      s6_sqd_raw  <= 58'(sq_r[28:0]) * 58'(s5_dnv_mag);
      s6_agi      <= s5_agi;
      s6_gloss_on <= s5_gloss_on;
      s6_status   <= s5_status;
    end
    if (ld[7]) begin
      s7_ag_raw   <= 60'(sqd_r[28:0]) * 60'(glps_pkg::K_GLOSS_GAIN);
      s7_agi      <= s6_agi;
      s7_gloss_on <= s6_gloss_on;
      s7_status   <= s6_status;
    end
  end

  // --------------------------------------------------------------------------
  // Colour channels: red, green, blue datapaths in parallel
  // --------------------------------------------------------------------------
  logic [15:0] gloss_f  [3];
  logic [15:0] albedo_f [3];
  logic [29:0] light_q  [3];
  logic [28:0] amb_q    [3];
  logic [29:0] amb_full [3];
  logic [33:0] ch_sum   [3];

  assign gloss_f[0]  = pixel.gloss_red;
  assign gloss_f[1]  = pixel.gloss_green;
  assign gloss_f[2]  = pixel.gloss_blue;
  assign albedo_f[0] = pixel.albedo_red;
  assign albedo_f[1] = pixel.albedo_green;
  assign albedo_f[2] = pixel.albedo_blue;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    // Light colour clamps to 2.0, ambient fraction to 1.0.
    assign light_q[c]  = glps_pkg::color_q28(light_color_packed[16*c +: 16],
                                             glps_pkg::LC_LIMIT);
    assign amb_full[c] = glps_pkg::color_q28(ambient_fraction_packed[16*c +: 16],
                                             30'(glps_pkg::Q_ONE));
    assign amb_q[c]    = amb_full[c][28:0];

    glps_channel u_chan (
      .clk          (clk),
      .load         (ld),
      .gloss_field  (gloss_f[c]),
      .albedo_field (albedo_f[c]),
      .light_q28    (light_q[c]),
      .amb_q28      (amb_q[c]),
      .dnl_mag      (dnl_mag),
      .dnl_pos      (s5_dnl_pos),
      .fg_eff       (fg_eff),
      .ag           (ag_s7),
      .agi          (s7_agi),
      .sum          (ch_sum[c])
    );
  end

  // --------------------------------------------------------------------------
  // Stages 8 to 10: carry status, round to Q3.13 and apply special cases
  // --------------------------------------------------------------------------
  glps_pkg::hit_status_t s8_status, s9_status, s10_status;
  logic [15:0] color_next [3];
  logic [15:0] s10_color  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (s9_status)
        glps_pkg::HIT_SHADED:      color_next[c] = glps_pkg::color_out(ch_sum[c]);
        glps_pkg::HIT_ZERO_NORMAL: color_next[c] = glps_pkg::COLOR_GREY;
        default:                   color_next[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s8_status <= s7_status;
    end
    if (ld[9]) begin
      s9_status <= s8_status;
    end
    if (ld[10]) begin
      s10_status <= s9_status;
      for (int c = 0; c < 3; c++) begin
        s10_color[c] <= color_next[c];
      end
    end
  end

  assign color.valid       = v[glps_pkg::PIPE_DEPTH];
  assign color.color_red   = s10_color[0];
  assign color.color_green = s10_color[1];
  assign color.color_blue  = s10_color[2];
  assign color.hit_status  = s10_status;

endmodule
